// ===== src/pixel_intensity_histogram_defines.svh =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_INTENSITY_HISTOGRAM_DEFINES_SVH
`define PIXEL_INTENSITY_HISTOGRAM_DEFINES_SVH

// Same-cycle implication.
`define PHIST_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PHIST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/phist_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram: package
// Field widths, operation and register codes, and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package phist_pkg;

	// Field widths.
	localparam int OP_W       = 2;
	localparam int PIX_W      = 17;
	localparam int SEL_W      = 10;
	localparam int BINS_W     = 11;
	localparam int TOTAL_W    = 32;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Divider geometry: the quotient is at most 17 bits for both uses.
	localparam int NUM_W  = 28;
	localparam int DEN_W  = 17;
	localparam int QUOT_W = 17;
	localparam int SH_W   = DEN_W + QUOT_W;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_COUNT      = 2'd0;
	localparam logic [OP_W-1:0] OP_READ       = 2'd1;
	localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_BIN_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

	// Register reset values.
	localparam logic [BINS_W-1:0] BIN_COUNT_RST  = 11'd500;
	localparam logic [PIX_W-1:0]  RANGE_LOW_RST  = 17'd0;
	localparam logic [PIX_W-1:0]  RANGE_HIGH_RST = 17'd65536;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [BINS_W-1:0] nb;
		logic [PIX_W-1:0]  lo;
		logic [PIX_W-1:0]  hi;
	} phist_cfg_t;

	// Item information that travels alongside the divider.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SEL_W-1:0] sel;
		logic             count_ok;
		logic             sel_ok;
	} phist_side_t;

endpackage

`default_nettype wire

// ===== src/phist_ifs.sv =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram: channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Item channel.
interface phist_in_if import phist_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [PIX_W-1:0] pixel_value;
	logic [SEL_W-1:0] bin_select;

	modport source (output valid, output operation, output pixel_value,
		output bin_select, input ready);
	modport sink (input valid, input operation, input pixel_value,
		input bin_select, output ready);
endinterface

// Result channel.
interface phist_out_if import phist_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] bin_total;
	logic [PIX_W-1:0]   bin_lower_edge;
	logic               bin_invalid;

	modport source (output valid, output bin_total, output bin_lower_edge,
		output bin_invalid, input ready);
	modport sink (input valid, input bin_total, input bin_lower_edge,
		input bin_invalid, output ready);
endinterface

// Register write channel.
interface phist_cfg_if import phist_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/phist_ram.sv =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module phist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/phist_divider.sv =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram: pipelined divider
// Restoring division, one quotient bit per stage, with item information
// carried alongside. The whole pipeline advances when en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module phist_divider import phist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  phist_side_t       in_side,
	output logic              out_valid,
	output logic [QUOT_W-1:0] out_quot,
	output phist_side_t       out_side
);

	// Stage registers; element zero is the divider input.
	logic              vld_s  [QUOT_W+1];
	logic [NUM_W-1:0]  rem_s  [QUOT_W+1];
	logic [DEN_W-1:0]  den_s  [QUOT_W+1];
	logic [QUOT_W-1:0] quot_s [QUOT_W+1];
	phist_side_t       side_s [QUOT_W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = in_num;
	assign den_s[0]  = in_den;
	assign quot_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		localparam int BIT = QUOT_W - 1 - k;

		logic [SH_W-1:0]   rem_ext;
		logic [SH_W-1:0]   den_sh;
		logic              ge;
		logic [NUM_W-1:0]  rem_nxt;
		logic [QUOT_W-1:0] quot_nxt;

		// Try to subtract the shifted divisor for this quotient bit.
		always_comb begin
			rem_ext  = SH_W'(rem_s[k]);
			den_sh   = SH_W'(den_s[k]) << BIT;
			ge       = (rem_ext >= den_sh);
			rem_nxt  = ge ? NUM_W'(rem_ext - den_sh) : rem_s[k];
			quot_nxt = quot_s[k];
			quot_nxt[BIT] = ge;
		end

		// Stage valid bit.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		// Stage payload.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nxt;
				den_s[k+1]  <= den_s[k];
				quot_s[k+1] <= quot_nxt;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUOT_W];
	assign out_quot  = quot_s[QUOT_W];
	assign out_side  = side_s[QUOT_W];

endmodule

`default_nettype wire

// ===== src/phist_bin_update.sv =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram: bin store and update
// Holds the bin counters in a RAM, clears it after reset, and performs the
// read-modify-write for counts and clears with one-deep write forwarding.
// Also holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_intensity_histogram_defines.svh"

module phist_bin_update import phist_pkg::*; #(
	parameter int MAX_BINS    = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  phist_cfg_t         cfg_view,
	input  logic               div_valid,
	input  logic [QUOT_W-1:0]  div_quot,
	input  phist_side_t        div_side,
	output logic               clearing,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [TOTAL_W-1:0] res_total,
	output logic [PIX_W-1:0]   res_edge,
	output logic               res_invalid
);

	localparam int IDX_W = $clog2(MAX_BINS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

	// Decode of the item leaving the divider (read-issue stage).
	logic [QUOT_W-1:0] nb_ext;
	logic [QUOT_W-1:0] bin_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic              a_count;
	logic              a_read;
	logic              a_clear;
	logic [PIX_W-1:0]  a_edge;

	// Memory stage registers.
	logic               b_valid_s2;
	logic               b_count_s2;
	logic               b_result_s2;
	logic               b_clear_s2;
	logic               b_invalid_s2;
	logic [PIX_W-1:0]   b_edge_s2;
	logic [IDX_W-1:0]   b_addr_s2;

	// Clearing pass.
	logic               clearing_q;
	logic [IDX_W-1:0]   clr_addr_q;

	// Last write, for forwarding.
	logic               lw_valid_q;
	logic [IDX_W-1:0]   lw_addr_q;
	logic [COUNT_WIDTH-1:0] lw_data_q;

	// Read-modify-write signals.
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] wr_value;
	logic [COUNT_WIDTH+TOTAL_W-1:0] cur_ext;
	logic [TOTAL_W-1:0]     cur_total;
	logic                   we_item;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	// Output register.
	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [PIX_W-1:0]   out_edge_q;
	logic               out_invalid_q;

	// Bin index from the quotient; a pixel at the top edge lands in the last bin.
	always_comb begin
		nb_ext  = QUOT_W'(cfg_view.nb);
		bin_idx = (div_quot >= nb_ext) ? QUOT_W'(nb_ext - 1'b1) : div_quot;
		a_count = div_valid && (div_side.op == OP_COUNT) && div_side.count_ok;
		a_read  = div_valid && ((div_side.op == OP_READ) || (div_side.op == OP_READ_CLEAR));
		a_clear = a_read && (div_side.op == OP_READ_CLEAR) && div_side.sel_ok;
		rd_addr = (div_side.op == OP_COUNT) ? IDX_W'(bin_idx) : IDX_W'(div_side.sel);
		a_edge  = (cfg_view.lo >= cfg_view.hi) ? cfg_view.lo
			: PIX_W'(cfg_view.lo + div_quot);
	end

	// Memory stage valid and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_s2 <= 1'b0;
		end else if (en) begin
			b_valid_s2 <= a_count || a_read;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_count_s2   <= a_count;
			b_result_s2  <= a_read;
			b_clear_s2   <= a_clear;
			b_invalid_s2 <= !div_side.sel_ok;
			b_edge_s2    <= a_edge;
			b_addr_s2    <= rd_addr;
		end
	end

	// Clearing pass over every entry after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_IDX) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clearing = clearing_q;

	// Current count, forwarded when the previous item wrote the same bin.
	always_comb begin
		cur = (lw_valid_q && (lw_addr_q == b_addr_s2)) ? lw_data_q : rd_data;
		if (b_count_s2) begin
			wr_value = (cur == '1) ? cur : cur + 1'b1;
		end else begin
			wr_value = '0;
		end
		cur_ext   = {{TOTAL_W{1'b0}}, cur};
		cur_total = ((cur_ext >> TOTAL_W) != '0) ? '1 : TOTAL_W'(cur);
		we_item   = en && b_valid_s2 && (b_count_s2 || b_clear_s2);
	end

	// RAM write port is shared between the clearing pass and item writes.
	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = we_item;
			ram_waddr = b_addr_s2;
			ram_wdata = wr_value;
		end
	end

	phist_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (MAX_BINS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Track the write made at the edge where the next item's read was issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (en) begin
			lw_valid_q <= we_item;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lw_addr_q <= b_addr_s2;
			lw_data_q <= wr_value;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && b_valid_s2 && b_result_s2) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && b_valid_s2 && b_result_s2) begin
			out_total_q   <= b_invalid_s2 ? '0 : cur_total;
			out_edge_q    <= b_invalid_s2 ? '0 : b_edge_s2;
			out_invalid_q <= b_invalid_s2;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_total   = out_total_q;
	assign res_edge    = out_edge_q;
	assign res_invalid = out_invalid_q;

	// No item reaches the memory stage while the store is being cleared.
	`PHIST_ASSERT_IMPLY(a_no_item_during_clear, clearing_q, !b_valid_s2,
		"item in memory stage during clearing pass")
	// A clearing read leaves a zero behind for forwarding.
	`PHIST_ASSERT_NEXT(a_clear_writes_zero, en && b_valid_s2 && b_clear_s2,
		lw_valid_q && (lw_data_q == '0), "bin clear did not write zero")
	// A counted pixel never wraps a counter to zero.
	`PHIST_ASSERT_IMPLY(a_count_saturates, we_item && b_count_s2, wr_value != '0,
		"bin counter wrapped")
	// A result appears only from a read leaving the memory stage.
	`PHIST_ASSERT_NEXT(a_result_from_read,
		!out_valid_q && !(en && b_valid_s2 && b_result_s2), !out_valid_q,
		"result without a read")

endmodule

`default_nettype wire

// ===== src/pixel_intensity_histogram.sv =====
// ----------------------------------------------------------------------------
// Pixel intensity histogram
// Counts 1.16 fixed-point grayscale pixels into bin_count equal-width bins
// over [range_low, range_high] and answers bin reads with the count and the
// lower edge of the bin, optionally clearing it. Items flow through a
// multiplier stage, a 17-stage pipelined divider (one quotient bit per
// stage) and a read-modify-write stage on the bin RAM. One item is taken
// per cycle; the whole pipeline holds while a finished result waits to be
// taken, so the rate is one item per cycle as long as results are taken
// when offered. Updates to the same bin in consecutive cycles are
// forwarded around the RAM. After reset the RAM is cleared one entry per
// cycle, and no item is taken until the clearing ends; register writes
// are taken at any time and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_intensity_histogram import phist_pkg::*; #(
	parameter int MAX_BINS    = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	phist_in_if.sink    pixels,
	phist_out_if.source results,
	phist_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [BINS_W-1:0] bin_count_q;
	logic [PIX_W-1:0]  range_low_q;
	logic [PIX_W-1:0]  range_high_q;

	// Input stage.
	phist_cfg_t        cfg_view;
	logic              en;
	logic              clearing;
	logic              accept;
	logic [PIX_W-1:0]  pix_off;
	logic [PIX_W-1:0]  span;
	logic [PIX_W-1:0]  mul_a;
	logic [PIX_W-1:0]  mul_b;
	logic [2*PIX_W-1:0] product;
	phist_side_t       side;
	logic              vld_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [DEN_W-1:0]  den_s1;
	phist_side_t       side_s1;

	// Divider output.
	logic              div_valid;
	logic [QUOT_W-1:0] div_quot;
	phist_side_t       div_side;

	// Result side.
	logic               res_valid;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q  <= BIN_COUNT_RST;
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_BIN_COUNT: begin
					bin_count_q <= cfg.data[BINS_W-1:0];
				end
				REG_RANGE_LOW: begin
					range_low_q <= cfg.data[PIX_W-1:0];
				end
				REG_RANGE_HIGH: begin
					range_high_q <= cfg.data[PIX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Bins in use are limited to the store depth.
	always_comb begin
		cfg_view.nb = ((32'(bin_count_q)) > 32'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bin_count_q;
		cfg_view.lo = range_low_q;
		cfg_view.hi = range_high_q;
	end

	// The pipeline advances unless a result waits untaken.
	assign en           = !(res_valid && !results.ready);
	assign pixels.ready = en && !clearing;
	assign accept       = pixels.valid && pixels.ready;

	// Operand selection and the one multiplier: pixel offset times bins for a
	// count, bin index times span for a read's lower edge.
	always_comb begin
		pix_off = pixels.pixel_value - cfg_view.lo;
		span    = cfg_view.hi - cfg_view.lo;
		side.op  = pixels.operation;
		side.sel = pixels.bin_select;
		side.count_ok = (cfg_view.nb != '0) && (cfg_view.lo < cfg_view.hi)
			&& (pixels.pixel_value >= cfg_view.lo) && (pixels.pixel_value <= cfg_view.hi);
		side.sel_ok = (BINS_W'(pixels.bin_select) < cfg_view.nb);
		if (pixels.operation == OP_COUNT) begin
			mul_a = pix_off;
			mul_b = PIX_W'(cfg_view.nb);
		end else begin
			mul_a = PIX_W'(pixels.bin_select);
			mul_b = span;
		end
		product = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept && (pixels.operation != OP_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= NUM_W'(product);
			den_s1  <= (pixels.operation == OP_COUNT) ? span : DEN_W'(cfg_view.nb);
			side_s1 <= side;
		end
	end

	phist_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_side   (side_s1),
		.out_valid (div_valid),
		.out_quot  (div_quot),
		.out_side  (div_side)
	);

	phist_bin_update #(
		.MAX_BINS    (MAX_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_bin_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cfg_view    (cfg_view),
		.div_valid   (div_valid),
		.div_quot    (div_quot),
		.div_side    (div_side),
		.clearing    (clearing),
		.res_valid   (res_valid),
		.res_ready   (results.ready),
		.res_total   (results.bin_total),
		.res_edge    (results.bin_lower_edge),
		.res_invalid (results.bin_invalid)
	);

	assign results.valid = res_valid;

endmodule

`default_nettype wire

// ===== tb/sv/pixel_intensity_histogram_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel intensity histogram testbench
// Sends pixel counts and bin reads through the item channel and reprograms
// the bin count and intensity range between phases. A local copy of the bin
// counters and registers predicts every bin readout. Each readout is compared
// field by field as it is taken from the result channel, while both sides of
// the handshake are throttled at random.
// ----------------------------------------------------------------------------

module pixel_intensity_histogram_test import phist_pkg::*; ();

	localparam int NUM_BINS        = 1024;
	localparam int SETTLE_CYCLES   = 40;
	localparam int STALL_LIMIT     = 4000;
	localparam int TRAFFIC_BLOCKS  = 16;
	localparam int ITEMS_PER_BLOCK = 34;
	localparam int PIX_MAX         = 131071;

	// One bin readout as it appears on the result channel.
	typedef struct packed {
		logic [TOTAL_W-1:0] bin_total;
		logic [PIX_W-1:0]   bin_lower_edge;
		logic               bin_invalid;
	} bin_readout_t;

	logic clk;
	logic arst_n;

	phist_in_if  pixels ();
	phist_out_if results ();
	phist_cfg_if cfg ();

	pixel_intensity_histogram DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixels),
		.results (results),
		.cfg     (cfg)
	);

	// Local copy of the histogram state and its registers.
	logic [TOTAL_W-1:0] bin_tally [NUM_BINS];
	logic [BINS_W-1:0]  cur_bin_count;
	logic [PIX_W-1:0]   cur_range_low;
	logic [PIX_W-1:0]   cur_range_high;
	int                 last_hit_bin;

	bin_readout_t pending_readouts [$];

	int error_count        = 0;
	int items_sent         = 0;
	int readouts_checked   = 0;
	int reg_writes         = 0;
	int idle_cycles        = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bins actually in use: counts above the store size are clipped.
	function automatic int unsigned bins_in_use();
		return (cur_bin_count > NUM_BINS) ? NUM_BINS : cur_bin_count;
	endfunction

	// Apply one accepted item to the local histogram and queue its readout.
	function automatic void apply_to_histogram(input logic [OP_W-1:0] op,
			input logic [PIX_W-1:0] pix, input logic [SEL_W-1:0] sel);
		int unsigned  nb;
		bit [63:0]    idx;
		bit [63:0]    edge_val;
		bin_readout_t readout;
		nb = bins_in_use();
		case (op)
			OP_COUNT: begin
				if (nb != 0 && cur_range_low < cur_range_high &&
						pix >= cur_range_low && pix <= cur_range_high) begin
					idx = ((64'(pix) - 64'(cur_range_low)) * 64'(nb)) /
						(64'(cur_range_high) - 64'(cur_range_low));
					if (idx >= nb)
						idx = 64'(nb - 1);
					if (bin_tally[idx] != '1)
						bin_tally[idx] = bin_tally[idx] + 1'b1;
					last_hit_bin = int'(idx);
				end
			end
			OP_READ, OP_READ_CLEAR: begin
				if (sel >= nb) begin
					readout = '{bin_total: '0, bin_lower_edge: '0, bin_invalid: 1'b1};
				end else begin
					// An empty range reports its low end as every edge.
					if (cur_range_low >= cur_range_high)
						edge_val = 64'(cur_range_low);
					else
						edge_val = 64'(cur_range_low) + (64'(sel) *
							(64'(cur_range_high) - 64'(cur_range_low))) / 64'(nb);
					readout.bin_total      = bin_tally[sel];
					readout.bin_lower_edge = edge_val[PIX_W-1:0];
					readout.bin_invalid    = 1'b0;
					if (op == OP_READ_CLEAR)
						bin_tally[sel] = '0;
				end
				pending_readouts = {pending_readouts, readout};
			end
			OP_UNUSED: ;
		endcase
	endfunction

	// Send one item, with random idle cycles ahead of it.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
			input logic [SEL_W-1:0] sel);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			pixels.valid <= 1'b0;
			@(negedge clk);
		end
		pixels.valid       <= 1'b1;
		pixels.operation   <= op;
		pixels.pixel_value <= pix;
		pixels.bin_select  <= sel;
		do @(posedge clk); while (!pixels.ready);
		apply_to_histogram(op, pix, sel);
		items_sent++;
	endtask

	// Write one register and mirror it into the local copy.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_BIN_COUNT:  cur_bin_count  = data[BINS_W-1:0];
			REG_RANGE_LOW:  cur_range_low  = data[PIX_W-1:0];
			REG_RANGE_HIGH: cur_range_high = data[PIX_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Stop sending and let every readout and pixel count drain out.
	task automatic settle();
		@(negedge clk);
		pixels.valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reprogram all three registers once the block is idle.
	task automatic set_histogram(input logic [CFG_DATA_W-1:0] nb_data,
			input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi);
		settle();
		write_reg(REG_BIN_COUNT, nb_data);
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
	endtask

	// Default registers: range ends, out-of-range pixel, unused operation,
	// reads of the first, last and first unused bins, clears of the last bin and of select 1023.
	task automatic test_default_extremes();
		send_item(OP_COUNT, 17'd0, '0);
		send_item(OP_COUNT, 17'd65536, '0);
		send_item(OP_COUNT, 17'd65535, 10'h3FF);
		send_item(OP_COUNT, 17'h1FFFF, '0);
		send_item(OP_UNUSED, 17'h1FFFF, 10'h3FF);
		send_item(OP_READ, '0, 10'd0);
		send_item(OP_READ_CLEAR, '0, 10'd499);
		send_item(OP_READ, '0, 10'd499);
		send_item(OP_READ, '0, 10'd500);
		send_item(OP_READ_CLEAR, '0, 10'h3FF);
		settle();
	endtask

	// Zero bins, and a bin count above the store size that gets clipped.
	task automatic test_bin_count_limits();
		set_histogram(17'd0, 17'd0, 17'd65536);
		send_item(OP_COUNT, 17'd100, '0);
		send_item(OP_READ, '0, 10'd0);
		set_histogram(17'd2047, 17'd1000, 17'd3000);
		send_item(OP_COUNT, 17'd999, '0);
		send_item(OP_COUNT, 17'd1000, '0);
		send_item(OP_COUNT, 17'd3000, '0);
		send_item(OP_COUNT, 17'd3001, '0);
		send_item(OP_READ_CLEAR, '0, 10'd1023);
		send_item(OP_READ, '0, 10'd0);
		settle();
	endtask

	// Equal and inverted range ends: nothing counts, edges read as the low end.
	task automatic test_empty_range();
		set_histogram(17'd1, 17'd40000, 17'd40000);
		send_item(OP_COUNT, 17'd40000, '0);
		send_item(OP_READ, '0, 10'd0);
		set_histogram(17'd1, 17'h1FFFF, 17'd0);
		send_item(OP_READ, '0, 10'd0);
		send_item(OP_READ_CLEAR, '0, 10'd1);
		settle();
	endtask

	// Random traffic over a series of register settings and pacing phases.
	task automatic test_random_traffic();
		int unsigned      mode;
		int unsigned      roll;
		int unsigned      nb;
		int unsigned      repeats;
		logic [CFG_DATA_W-1:0] nb_data;
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		logic [OP_W-1:0]  op;
		logic [PIX_W-1:0] pix;
		logic [SEL_W-1:0] sel;
		for (int blk = 0; blk < TRAFFIC_BLOCKS; blk++) begin
			// Pacing: none, sender idling, receiver stalling, then both.
			case (blk / 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
				default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
			endcase

			// The first blocks go through every kind of setting once.
			mode = (blk < 6) ? blk : $urandom_range(5);
			case (mode)
				0: begin
					nb_data = CFG_DATA_W'($urandom_range(1, NUM_BINS));
					lo = 17'd0;
					hi = 17'd65536;
				end
				1: begin
					nb_data = CFG_DATA_W'($urandom_range(1, 8));
					lo = PIX_W'($urandom_range(0, 65535));
					hi = PIX_W'($urandom_range(lo + 1, 65536));
				end
				2: begin
					nb_data = $urandom_range(1) ? 17'd2047 : 17'd1024;
					lo = 17'd0;
					hi = 17'd65536;
				end
				3: begin
					nb_data = 17'd1;
					lo = PIX_W'($urandom_range(0, 65000));
					hi = PIX_W'(lo + $urandom_range(1, 500));
				end
				4: begin
					nb_data = CFG_DATA_W'($urandom_range(0, 3));
					lo = PIX_W'($urandom_range(0, PIX_MAX));
					hi = PIX_W'($urandom_range(0, lo));
				end
				default: begin
					// Unused upper data bits and ranges past 1.0 included.
					nb_data = CFG_DATA_W'($urandom_range(0, PIX_MAX));
					lo = PIX_W'($urandom_range(0, PIX_MAX - 1));
					hi = PIX_W'($urandom_range(lo + 1, PIX_MAX));
				end
			endcase
			set_histogram(nb_data, lo, hi);
			nb = bins_in_use();

			for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
				roll = $urandom_range(99);
				if (roll < 60)
					op = OP_COUNT;
				else if (roll < 78)
					op = OP_READ;
				else if (roll < 95)
					op = OP_READ_CLEAR;
				else
					op = OP_UNUSED;

				// Mostly pixels inside the range, some at its ends, some anywhere.
				roll = $urandom_range(99);
				if (roll < 70 && lo < hi)
					pix = PIX_W'($urandom_range(lo, hi));
				else if (roll < 80)
					pix = $urandom_range(1) ? lo : hi;
				else
					pix = PIX_W'($urandom_range(0, PIX_MAX));

				// Reads favor bins that have just been counted.
				roll = $urandom_range(99);
				if (roll < 45)
					sel = SEL_W'(last_hit_bin);
				else if (roll < 85 && nb != 0)
					sel = SEL_W'($urandom_range(0, nb - 1));
				else
					sel = SEL_W'($urandom_range(0, NUM_BINS - 1));

				// Now and then a burst of identical items hits one bin back to back.
				repeats = ($urandom_range(9) == 0) ? $urandom_range(2, 4) : 1;
				repeat (repeats) send_item(op, pix, sel);
			end
		end
		settle();
	endtask

	// Result receiver: ready is throttled at random.
	initial begin
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			results.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Compare each transfer on the result channel with the oldest prediction.
	always @(posedge clk) begin : check_readout
		bin_readout_t want;
		if (arst_n && results.valid && results.ready) begin
			if (pending_readouts.size() == 0) begin
				$error("Unexpected bin readout: total %0d, edge %0d, invalid %0b.",
					results.bin_total, results.bin_lower_edge, results.bin_invalid);
				error_count++;
			end else begin
				want = pending_readouts.pop_front();
				if (results.bin_total !== want.bin_total) begin
					$error("bin_total mismatch: expected %0d, got %0d.",
						want.bin_total, results.bin_total);
					error_count++;
				end
				if (results.bin_lower_edge !== want.bin_lower_edge) begin
					$error("bin_lower_edge mismatch: expected %0d, got %0d.",
						want.bin_lower_edge, results.bin_lower_edge);
					error_count++;
				end
				if (results.bin_invalid !== want.bin_invalid) begin
					$error("bin_invalid mismatch: expected %0b, got %0b.",
						want.bin_invalid, results.bin_invalid);
					error_count++;
				end
				readouts_checked++;
			end
		end
	end

	// Watchdog: the run ends if no transfer happens on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixels.valid && pixels.ready) || (results.valid && results.ready) ||
					(cfg.valid && cfg.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n             = 1'b0;
		pixels.valid       = 1'b0;
		pixels.operation   = OP_COUNT;
		pixels.pixel_value = '0;
		pixels.bin_select  = '0;
		cfg.valid          = 1'b0;
		cfg.index          = REG_BIN_COUNT;
		cfg.data           = '0;
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		cur_bin_count  = BIN_COUNT_RST;
		cur_range_low  = RANGE_LOW_RST;
		cur_range_high = RANGE_HIGH_RST;
		last_hit_bin   = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_default_extremes();
		test_bin_count_limits();
		test_empty_range();
		test_random_traffic();

		$display("Sent %0d items and checked %0d bin readouts over %0d register writes,",
			items_sent, readouts_checked, reg_writes);
		$display("with free-running, sender-idle, receiver-stall and mixed pacing.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/phist_pkg.sv
src/phist_ifs.sv
src/phist_ram.sv
src/phist_divider.sv
src/phist_bin_update.sv
src/pixel_intensity_histogram.sv
tb/sv/pixel_intensity_histogram_test.sv
